// ----- src/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token kinds, character classes and the token record type.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_BITS  = 16;
  localparam int LEN_BITS  = 8;
  localparam int LINE_BITS = 16;
  localparam int KIND_BITS = 6;
  localparam int MAX_TOKENS = 3;
  localparam int QDEPTH    = 4;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_NAME      = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD0  = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_OP_SINGLE = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_OP_EQUAL  = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_AND       = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_OR        = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_BRACKET0  = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_END       = 6'd41;
  localparam logic [KIND_BITS-1:0] KIND_ERROR     = 6'd42;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_EQUAL = "=";
  localparam logic [7:0] CHAR_UNDER = "_";

  localparam logic [3:0] OP_IDX_AMP  = 4'd9;
  localparam logic [3:0] OP_IDX_PIPE = 4'd10;

  localparam int NUM_KEYWORDS = 6;
  localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][8] = '{
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4};

  typedef struct packed {
    logic                 last;
    logic [7:0]           bad;
    logic [LINE_BITS-1:0] line;
    logic [LEN_BITS-1:0]  length;
    logic [POS_BITS-1:0]  offset;
    logic [KIND_BITS-1:0] kind;
  } token_t;

  typedef struct packed {
    logic [1:0]                  count;
    token_t [MAX_TOKENS-1:0]     tokens;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } class_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic class_t op_class(logic [7:0] c);
    class_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.idx = 4'd0;
      "-":     r.idx = 4'd1;
      "*":     r.idx = 4'd2;
      "/":     r.idx = 4'd3;
      "%":     r.idx = 4'd4;
      "=":     r.idx = 4'd5;
      "!":     r.idx = 4'd6;
      ">":     r.idx = 4'd7;
      "<":     r.idx = 4'd8;
      "&":     r.idx = OP_IDX_AMP;
      "|":     r.idx = OP_IDX_PIPE;
      "^":     r.idx = 4'd11;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic class_t bracket_class(logic [7:0] c);
    class_t r;
    r.hit = 1'b1;
    case (c)
      "(":     r.idx = 4'd0;
      ")":     r.idx = 4'd1;
      "{":     r.idx = 4'd2;
      "}":     r.idx = 4'd3;
      "[":     r.idx = 4'd4;
      "]":     r.idx = 4'd5;
      ";":     r.idx = 4'd6;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Keeps the keywords whose character at position k equals c.
  function automatic logic [NUM_KEYWORDS-1:0] kw_match(logic [7:0] c,
                                                       logic [LEN_BITS-1:0] k);
    logic [NUM_KEYWORDS-1:0] m;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      m[i] = (k < LEN_BITS'(KW_LEN[i])) && (c == KW_TEXT[i][k[2:0]]);
    end
    return m;
  endfunction

  function automatic logic [KIND_BITS-1:0] name_kind(logic [NUM_KEYWORDS-1:0] cand,
                                                     logic [LEN_BITS-1:0] len);
    logic [KIND_BITS-1:0] k;
    k = KIND_NAME;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (cand[i] && (len == LEN_BITS'(KW_LEN[i]))) begin
        k = KIND_KEYWORD0 + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

  function automatic token_t mk_token(logic [KIND_BITS-1:0] kind,
                                      logic [POS_BITS-1:0] offset,
                                      logic [LEN_BITS-1:0] length,
                                      logic [LINE_BITS-1:0] line,
                                      logic [7:0] bad);
    token_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = length;
    t.line   = line;
    t.bad    = bad;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ----- src/stt_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Holds the scan state and turns each accepted byte into up to three tokens.
// ----------------------------------------------------------------------------
module stt_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [7:0]                 byte_i,
  input  logic                       last_i,
  output stt_pkg::bundle_t           bundle_o
);

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_NUMBER   = 3'd1;
  localparam logic [2:0] MODE_NAME     = 3'd2;
  localparam logic [2:0] MODE_OPERATOR = 3'd3;
  localparam logic [2:0] MODE_HALTED   = 3'd4;

  logic [2:0]                         mode_q, mode_d;
  logic [3:0]                         op_q, op_d;
  logic [stt_pkg::POS_BITS-1:0]       start_q, start_d;
  logic [stt_pkg::LEN_BITS-1:0]       len_q, len_d;
  logic [stt_pkg::LINE_BITS-1:0]      line_q, line_d;
  logic [stt_pkg::POS_BITS-1:0]       pos_q, pos_d;
  logic [stt_pkg::NUM_KEYWORDS-1:0]   kw_q, kw_d;

  stt_pkg::bundle_t                   bundle;
  stt_pkg::class_t                    op_c, br_c;
  logic                               consumed;
  logic [stt_pkg::POS_BITS-1:0]       pos_next;
  logic [stt_pkg::LINE_BITS-1:0]      end_line;
  logic [1:0]                         n;

  always_comb begin
    mode_d   = mode_q;
    op_d     = op_q;
    start_d  = start_q;
    len_d    = len_q;
    line_d   = line_q;
    pos_d    = pos_q;
    kw_d     = kw_q;
    bundle   = '0;
    n        = 2'd0;
    consumed = 1'b0;
    op_c     = stt_pkg::op_class(byte_i);
    br_c     = stt_pkg::bracket_class(byte_i);
    pos_next = pos_q + 1'b1;
    end_line = '0;

    if (mode_q == MODE_HALTED) begin
      if (last_i) begin
        mode_d  = MODE_IDLE;
        op_d    = '0;
        start_d = '0;
        len_d   = '0;
        line_d  = stt_pkg::LINE_BITS'(1);
        pos_d   = '0;
        kw_d    = '1;
      end
    end else begin
      case (mode_q)
        MODE_NUMBER: begin
          if (stt_pkg::is_digit(byte_i)) begin
            if (len_q != stt_pkg::LEN_MAX) len_d = len_q + 1'b1;
            consumed = 1'b1;
          end else begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_NUMBER, start_q, len_q,
                                                 line_q, 8'd0);
            n      = n + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_NAME: begin
          if (stt_pkg::is_digit(byte_i) || stt_pkg::is_alpha(byte_i)) begin
            kw_d = kw_q & stt_pkg::kw_match(byte_i, len_q);
            if (len_q != stt_pkg::LEN_MAX) len_d = len_q + 1'b1;
            consumed = 1'b1;
          end else begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::name_kind(kw_q, len_q), start_q,
                                                 len_q, line_q, 8'd0);
            n      = n + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_OPERATOR: begin
          if (byte_i == stt_pkg::CHAR_EQUAL) begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_OP_EQUAL + {2'b00, op_q},
                                                 start_q, stt_pkg::LEN_BITS'(2), line_q, 8'd0);
            consumed = 1'b1;
          end else if (op_c.hit && op_c.idx == stt_pkg::OP_IDX_AMP
                       && op_q == stt_pkg::OP_IDX_AMP) begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_AND, start_q,
                                                 stt_pkg::LEN_BITS'(2), line_q, 8'd0);
            consumed = 1'b1;
          end else if (op_c.hit && op_c.idx == stt_pkg::OP_IDX_PIPE
                       && op_q == stt_pkg::OP_IDX_PIPE) begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_OR, start_q,
                                                 stt_pkg::LEN_BITS'(2), line_q, 8'd0);
            consumed = 1'b1;
          end else begin
            bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_OP_SINGLE + {2'b00, op_q},
                                                 start_q, stt_pkg::LEN_BITS'(1), line_q, 8'd0);
          end
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end
        default: begin
        end
      endcase

      if (!consumed) begin
        if (stt_pkg::is_space(byte_i)) begin
          if (byte_i == stt_pkg::CHAR_LF && line_q != stt_pkg::LINE_MAX) begin
            line_d = line_q + 1'b1;
          end
        end else if (stt_pkg::is_digit(byte_i)) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
          len_d   = stt_pkg::LEN_BITS'(1);
        end else if (stt_pkg::is_alpha(byte_i) || byte_i == stt_pkg::CHAR_UNDER) begin
          mode_d  = MODE_NAME;
          start_d = pos_q;
          kw_d    = stt_pkg::kw_match(byte_i, '0);
          len_d   = stt_pkg::LEN_BITS'(1);
        end else if (op_c.hit) begin
          mode_d  = MODE_OPERATOR;
          op_d    = op_c.idx;
          start_d = pos_q;
        end else if (br_c.hit) begin
          bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_BRACKET0 + {2'b00, br_c.idx},
                                               pos_q, stt_pkg::LEN_BITS'(1), line_d, 8'd0);
          n = n + 2'd1;
        end else begin
          bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_ERROR, pos_q,
                                               stt_pkg::LEN_BITS'(1), line_d, byte_i);
          n      = n + 2'd1;
          mode_d = MODE_HALTED;
        end
      end

      pos_d = pos_next;

      if (last_i) begin
        if (mode_d != MODE_HALTED) begin
          end_line = (line_d != stt_pkg::LINE_MAX) ? line_d + 1'b1 : line_d;
          case (mode_d)
            MODE_NUMBER: begin
              bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_NUMBER, start_d, len_d,
                                                   line_d, 8'd0);
              n = n + 2'd1;
            end
            MODE_NAME: begin
              bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::name_kind(kw_d, len_d), start_d,
                                                   len_d, line_d, 8'd0);
              n = n + 2'd1;
            end
            MODE_OPERATOR: begin
              bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_OP_SINGLE + {2'b00, op_d},
                                                   start_d, stt_pkg::LEN_BITS'(1), line_d,
                                                   8'd0);
              n = n + 2'd1;
            end
            default: begin
            end
          endcase
          bundle.tokens[n] = stt_pkg::mk_token(stt_pkg::KIND_END, pos_next, '0, end_line,
                                               8'd0);
          n = n + 2'd1;
        end
        mode_d  = MODE_IDLE;
        op_d    = '0;
        start_d = '0;
        len_d   = '0;
        line_d  = stt_pkg::LINE_BITS'(1);
        pos_d   = '0;
        kw_d    = '1;
      end
    end

    if (n != 2'd0) bundle.tokens[n - 2'd1].last = 1'b1;
    bundle.count = n;
  end

  assign bundle_o = accept_i ? bundle : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      op_q    <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= stt_pkg::LINE_BITS'(1);
      pos_q   <= '0;
      kw_q    <= '1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      op_q    <= op_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      kw_q    <= kw_d;
    end
  end

endmodule

// ----- src/stt_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer output queue
// Small shifting queue that takes up to three tokens per cycle and hands
// out one token per beat.
// ----------------------------------------------------------------------------
module stt_out_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stt_pkg::bundle_t           bundle_i,
  output logic                       space_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output stt_pkg::token_t            token_o
);

  stt_pkg::token_t                   entry_q [stt_pkg::QDEPTH];
  stt_pkg::token_t                   entry_d [stt_pkg::QDEPTH];
  logic [stt_pkg::QCNT_BITS-1:0]     cnt_q, cnt_d;
  logic [stt_pkg::QCNT_BITS-1:0]     base;
  logic                              pop;

  assign pop     = (cnt_q != '0) && ready_i;
  assign valid_o = (cnt_q != '0);
  assign token_o = entry_q[0];
  assign space_o = (cnt_q <= stt_pkg::QCNT_BITS'(stt_pkg::QDEPTH - stt_pkg::MAX_TOKENS));

  always_comb begin
    base = cnt_q - stt_pkg::QCNT_BITS'(pop);
    for (int i = 0; i < stt_pkg::QDEPTH - 1; i++) begin
      entry_d[i] = pop ? entry_q[i+1] : entry_q[i];
    end
    entry_d[stt_pkg::QDEPTH-1] = entry_q[stt_pkg::QDEPTH-1];
    for (int i = 0; i < stt_pkg::QDEPTH; i++) begin
      for (int j = 0; j < stt_pkg::MAX_TOKENS; j++) begin
        if ((2'(j) < bundle_i.count)
            && (base + stt_pkg::QCNT_BITS'(j) == stt_pkg::QCNT_BITS'(i))) begin
          entry_d[i] = bundle_i.tokens[j];
        end
      end
    end
    cnt_d = base + stt_pkg::QCNT_BITS'(bundle_i.count);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < stt_pkg::QDEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Scans source text one byte per beat and emits one token record per beat.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while its output queue has room. A
// byte that completes two or three tokens (a pending token, a bracket or
// error, and the end token on the last byte) places them all in a four-entry
// output queue at once, and input is held off until the queue has room for
// three tokens again. The tokens of each input byte are registered into the
// output queue. After an error token the block drops bytes until the byte
// marked last, then starts a new text.
module source_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // token_kind, token_offset, token_length,
                                        // line_number, offending_byte, zero pad
  output logic        m_axis_tlast_o    // last_of_run
);

  stt_pkg::bundle_t bundle;
  stt_pkg::token_t  token;
  logic             accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  stt_scanner u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .bundle_o (bundle)
  );

  stt_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .space_o  (s_axis_tready_o),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .token_o  (token)
  );

  assign m_axis_tdata_o = {2'b00, token.bad, token.line, token.length, token.offset,
                           token.kind};
  assign m_axis_tlast_o = token.last;

endmodule

// ----- verif/tb_source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams source text into the tokenizer and checks every token record it
// returns against a scanner kept in the testbench. A short directed text
// comes first, then random texts made mostly of well-formed tokens with some
// noise bytes. Idling changes by phase, one phase holds the output side off
// for a long stretch, and one long name drives the length limit.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;

  import stt_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 16;
  localparam int PRINT_LIMIT    = 40;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_NAME,
    SCAN_OPER,
    SCAN_HALT
  } scan_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  logic hold_ask    = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int errors        = 0;
  int tokens_seen   = 0;
  int bytes_sent    = 0;

  string kw_word [NUM_KEYWORDS] = '{"true", "false", "var", "if", "else", "loop"};
  string op_chars      = "+-*/%=!><&|^";
  string bracket_chars = "(){}[];";

  // Scanner state that mirrors the block.
  scan_e                 scan_state;
  logic [7:0]            held_op;
  logic [POS_BITS-1:0]   tok_start;
  logic [LEN_BITS-1:0]   tok_len;
  logic [LINE_BITS-1:0]  cur_line;
  logic [POS_BITS-1:0]   next_pos;
  logic [NUM_KEYWORDS-1:0] kw_cand;

  token_t batch[$];
  token_t tokens_due[$];

  always #1 clk_i = ~clk_i;

  source_text_tokenizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------- scanner

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int op_code(logic [7:0] c);
    for (int i = 0; i < op_chars.len(); i++) begin
      if (op_chars[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int bracket_code(logic [7:0] c);
    for (int i = 0; i < bracket_chars.len(); i++) begin
      if (bracket_chars[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  task reset_scanner();
    scan_state = SCAN_IDLE;
    held_op    = 8'h00;
    tok_start  = '0;
    tok_len    = '0;
    cur_line   = 1;
    next_pos   = '0;
    kw_cand    = '1;
  endtask

  task prune_keywords(input logic [7:0] c, input int k);
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (k >= kw_word[i].len() || kw_word[i][k] != c) begin
        kw_cand[i] = 1'b0;
      end
    end
  endtask

  function automatic logic [KIND_BITS-1:0] name_token_kind();
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (kw_cand[i] && kw_word[i].len() == tok_len) begin
        return KIND_KEYWORD0 + KIND_BITS'(i);
      end
    end
    return KIND_NAME;
  endfunction

  task add_token(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] off,
                 input logic [LEN_BITS-1:0] len, input logic [LINE_BITS-1:0] line,
                 input logic [7:0] bad);
    token_t t;
    t.kind   = kind;
    t.offset = off;
    t.length = len;
    t.line   = line;
    t.bad    = bad;
    t.last   = 1'b0;
    batch.push_back(t);
  endtask

  task flush_pending();
    case (scan_state)
      SCAN_NUMBER: add_token(KIND_NUMBER, tok_start, tok_len, cur_line, 8'h00);
      SCAN_NAME:   add_token(name_token_kind(), tok_start, tok_len, cur_line, 8'h00);
      SCAN_OPER:   add_token(KIND_OP_SINGLE + KIND_BITS'(op_code(held_op)), tok_start, 1,
                             cur_line, 8'h00);
      default: ;
    endcase
    scan_state = SCAN_IDLE;
  endtask

  task predict_tokens(input logic [7:0] c, input logic eot);
    logic                 took;
    int                   oi;
    int                   bi;
    logic [POS_BITS-1:0]  here;
    logic [LINE_BITS-1:0] end_line;
    took = 1'b0;
    here = next_pos;
    batch.delete();
    if (scan_state == SCAN_HALT) begin
      if (eot) begin
        reset_scanner();
      end
      return;
    end
    case (scan_state)
      SCAN_NUMBER: begin
        if (is_dec(c)) begin
          if (tok_len < LEN_MAX) tok_len++;
          took = 1'b1;
        end else begin
          flush_pending();
        end
      end
      SCAN_NAME: begin
        if (is_dec(c) || is_letter(c)) begin
          prune_keywords(c, tok_len);
          if (tok_len < LEN_MAX) tok_len++;
          took = 1'b1;
        end else begin
          flush_pending();
        end
      end
      SCAN_OPER: begin
        oi = op_code(held_op);
        if (c == CHAR_EQUAL) begin
          add_token(KIND_OP_EQUAL + KIND_BITS'(oi), tok_start, 2, cur_line, 8'h00);
          took = 1'b1;
        end else if (c == "&" && held_op == "&") begin
          add_token(KIND_AND, tok_start, 2, cur_line, 8'h00);
          took = 1'b1;
        end else if (c == "|" && held_op == "|") begin
          add_token(KIND_OR, tok_start, 2, cur_line, 8'h00);
          took = 1'b1;
        end else begin
          add_token(KIND_OP_SINGLE + KIND_BITS'(oi), tok_start, 1, cur_line, 8'h00);
        end
        scan_state = SCAN_IDLE;
      end
      default: ;
    endcase
    if (!took) begin
      bi = bracket_code(c);
      if (is_blank(c)) begin
        if (c == CHAR_LF && cur_line < LINE_MAX) cur_line++;
      end else if (is_dec(c)) begin
        scan_state = SCAN_NUMBER;
        tok_start  = here;
        tok_len    = 1;
      end else if (is_letter(c) || c == CHAR_UNDER) begin
        scan_state = SCAN_NAME;
        tok_start  = here;
        kw_cand    = '1;
        prune_keywords(c, 0);
        tok_len    = 1;
      end else if (op_code(c) >= 0) begin
        scan_state = SCAN_OPER;
        held_op    = c;
        tok_start  = here;
      end else if (bi >= 0) begin
        add_token(KIND_BRACKET0 + KIND_BITS'(bi), here, 1, cur_line, 8'h00);
      end else begin
        add_token(KIND_ERROR, here, 1, cur_line, c);
        scan_state = SCAN_HALT;
      end
    end
    next_pos++;
    if (eot) begin
      if (scan_state != SCAN_HALT) begin
        end_line = (cur_line < LINE_MAX) ? cur_line + 1'b1 : LINE_MAX;
        flush_pending();
        add_token(KIND_END, next_pos, 0, end_line, 8'h00);
      end
      reset_scanner();
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) tokens_due.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task report_error(input string msg);
    if (errors < PRINT_LIMIT) $display("[%0t] token %0d: %s", $realtime, tokens_seen, msg);
    errors++;
  endtask

  task compare_field(input string name, input int unsigned got, input int unsigned want);
    if (got !== want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task check_token(input token_t got);
    token_t want;
    if (tokens_due.size() == 0) begin
      report_error($sformatf("kind %0d at offset %0d arrived with none expected",
                             got.kind, got.offset));
      return;
    end
    want = tokens_due.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("offset", got.offset, want.offset);
    compare_field("length", got.length, want.length);
    compare_field("line", got.line, want.line);
    compare_field("offending byte", got.bad, want.bad);
    compare_field("tlast", got.last, want.last);
  endtask

  initial reset_scanner();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) predict_tokens(s_tdata, s_tlast);
      if (m_axis_tvalid_o && m_tready) begin
        check_token(token_t'({m_axis_tlast_o, m_axis_tdata_o[53:0]}));
        tokens_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  task send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  task send_random_text();
    logic [7:0] txt[$];
    string      w;
    int         r;
    int         n;
    txt.delete();
    repeat ($urandom_range(12, 2)) begin
      r = $urandom_range(99);
      if (r < 14) begin
        w = kw_word[$urandom_range(NUM_KEYWORDS - 1)];
        n = ($urandom_range(4) == 0) ? w.len() - 1 : w.len();
        for (int i = 0; i < n; i++) txt.push_back(w[i]);
        if ($urandom_range(3) == 0) txt.push_back(rand_letter());
      end else if (r < 30) begin
        txt.push_back($urandom_range(4) == 0 ? CHAR_UNDER : rand_letter());
        repeat ($urandom_range(7)) begin
          case ($urandom_range(5))
            0:       txt.push_back(8'("0" + $urandom_range(9)));
            1:       txt.push_back(CHAR_UNDER);
            default: txt.push_back(rand_letter());
          endcase
        end
      end else if (r < 42) begin
        repeat ($urandom_range(6, 1)) txt.push_back(8'("0" + $urandom_range(9)));
      end else if (r < 62) begin
        n = $urandom_range(op_chars.len() - 1);
        txt.push_back(op_chars[n]);
        case ($urandom_range(4))
          0, 1: txt.push_back(CHAR_EQUAL);
          2:    if (op_chars[n] == "&" || op_chars[n] == "|") txt.push_back(op_chars[n]);
          default: ;
        endcase
      end else if (r < 74) begin
        txt.push_back(bracket_chars[$urandom_range(bracket_chars.len() - 1)]);
      end else if (r < 97) begin
        case ($urandom_range(3))
          0:       txt.push_back(CHAR_LF);
          1:       txt.push_back(8'($urandom_range(13, 9)));
          default: txt.push_back(" ");
        endcase
      end else begin
        txt.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(1)) txt.push_back(" ");
    end
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // ---------------------------------------------------------------- tests

  task test_directed();
    send_text("if(_x_1>=42){a&&b||c-=9;}\n");
    send_byte(8'h00, 1'b0);
    send_byte("q", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("7");
    send_byte(8'hFF, 1'b1);
  endtask

  task test_random_texts(input int amount);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < amount) send_random_text();
  endtask

  // Every last byte here completes three tokens, so the output queue fills
  // quickly while the output side is held off.
  task test_backpressure();
    hold_ask = 1'b1;
    repeat (15) send_text("a+(");
  endtask

  // A name longer than the length field can hold, followed by a short tail.
  task test_saturation();
    repeat (257) send_byte("a", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("x", 1'b0);
    send_byte("<", 1'b0);
    send_byte(CHAR_EQUAL, 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct  = 21;
    sink_idle_pct = 76;
    test_directed();
    test_random_texts(40);

    src_idle_pct  = 76;
    sink_idle_pct = 21;
    test_random_texts(40);
    test_backpressure();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_texts(40);
    test_saturation();

    s_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
